// ===== src/nam_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nam_pkg: shared constants and types of the nearest angle matcher
// Q.16 angle constants, opcodes and the controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package nam_pkg;

	localparam int MAX_CANDIDATES_DEF = 16;

	localparam int OP_W      = 2;
	localparam int ANGLE_W   = 24;
	localparam int WANG_W    = 19;   // wrapped angle, 0 .. 2*pi
	localparam int DIST_W    = 20;   // distance and running best
	localparam int RED_W     = 26;   // offset angle during reduction
	localparam int OUT_IDX_W = 4;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

	// 2*pi in Q.16
	localparam logic [WANG_W-1:0] TWO_PI_Q16 = 19'd411775;
	// 15.00 in Q.16, start value of the running best
	localparam logic [DIST_W-1:0] START_BEST = 20'd983040;
	// 21 * 2*pi, lifts every 24-bit signed angle above zero
	localparam logic [RED_W-1:0]  WRAP_OFFSET = 26'd8647275;

	// quotient bits of the reduction: 2*pi*32 down to 2*pi*1
	localparam int WRAP_STEPS = 6;
	localparam int WSTEP_W    = 3;

	typedef struct packed {
		logic               load;      // latch the accepted item
		logic               wrap_en;   // one compare/subtract of the reduction
		logic [WSTEP_W-1:0] wrap_bit;  // which multiple of 2*pi
		logic               clear;
		logic               append;
		logic               scan_init; // reset read pointer and running best
		logic               rd_en;     // read one candidate, advance pointer
		logic               out_load;  // move the answer into the output register
	} nam_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            count_zero;
		logic            rd_last;     // pointer sits on the last stored entry
	} nam_stat_t;

endpackage
`default_nettype wire

// ===== src/nam_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nam_req_if / nam_rsp_if: valid/ready channels of the nearest angle matcher
// Request carries one opcode item, response carries one match item.
// ----------------------------------------------------------------------------
interface nam_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [23:0] angle;
	logic        last_query;

	modport source (output valid, output opcode, output angle, output last_query,
		input ready);
	modport sink (input valid, input opcode, input angle, input last_query,
		output ready);
endinterface

interface nam_rsp_if;
	logic        valid;
	logic        ready;
	logic [18:0] matched_angle;
	logic [3:0]  matched_index;
	logic        empty_res;
	logic        last;

	modport source (output valid, output matched_angle, output matched_index,
		output empty_res, output last, input ready);
	modport sink (input valid, input matched_angle, input matched_index,
		input empty_res, input last, output ready);
endinterface
`default_nettype wire

// ===== src/nam_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nam_datapath: wrap unit, candidate store, distance search and output register
// Reduction is one restoring step per cycle; the scan reads one entry per cycle.
// ----------------------------------------------------------------------------
module nam_datapath #(
	parameter int MAX_CANDIDATES = nam_pkg::MAX_CANDIDATES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nam_pkg::nam_cmd_t                   cmd,
	output nam_pkg::nam_stat_t                  stat,
	input  logic [nam_pkg::OP_W-1:0]            opcode,
	input  logic signed [nam_pkg::ANGLE_W-1:0]  angle,
	input  logic                                last_query,
	output logic [nam_pkg::WANG_W-1:0]          matched_angle,
	output logic [nam_pkg::OUT_IDX_W-1:0]       matched_index,
	output logic                                empty_res,
	output logic                                last
);
	import nam_pkg::*;

	localparam int IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_CANDIDATES);

	logic [OP_W-1:0]   op_q;
	logic              lastq_q;
	logic [RED_W-1:0]  red_q;
	logic [RED_W-1:0]  red_sub;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  ptr_q;
	logic [WANG_W-1:0] mem [MAX_CANDIDATES];
	logic [WANG_W-1:0] rd_data_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic              rd_vld_s1;
	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [WANG_W-1:0] best_ang_q;
	logic [WANG_W-1:0] wq;
	logic signed [DIST_W-1:0] diff;
	logic [DIST_W-1:0] abs_dist;

	assign wq       = red_q[WANG_W-1:0];
	assign red_sub  = RED_W'(TWO_PI_Q16) << cmd.wrap_bit;
	assign diff     = $signed({1'b0, wq}) - $signed({1'b0, rd_data_s1});
	assign abs_dist = diff[DIST_W-1] ? DIST_W'(-diff) : DIST_W'(diff);

	assign stat.op         = op_q;
	assign stat.count_zero = (count_q == '0);
	assign stat.rd_last    = (CNT_W'(ptr_q) == count_q - CNT_W'(1));

	// item latch and reduction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			lastq_q <= last_query;
			red_q   <= RED_W'(angle) + WRAP_OFFSET;
		end else if (cmd.wrap_en && red_q >= red_sub) begin
			red_q <= red_q - red_sub;
		end
	end

	// fill count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.append && count_q != CNT_FULL) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.scan_init) begin
				ptr_q <= '0;
			end else if (cmd.rd_en) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	// candidate store
	always_ff @(posedge clk) begin
		if (cmd.append && count_q != CNT_FULL) begin
			mem[count_q[IDX_W-1:0]] <= wq;
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem[ptr_q];
			rd_idx_s1  <= ptr_q;
		end
	end

	// running best; strict less keeps the earliest on ties
	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			best_q     <= START_BEST;
			best_idx_q <= '0;
			best_ang_q <= '0;
		end else if (rd_vld_s1 && abs_dist < best_q) begin
			best_q     <= abs_dist;
			best_idx_q <= rd_idx_s1;
			best_ang_q <= rd_data_s1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			last <= lastq_q;
			if (count_q == '0) begin
				matched_angle <= '0;
				matched_index <= '0;
				empty_res     <= 1'b1;
			end else begin
				matched_angle <= best_ang_q;
				matched_index <= OUT_IDX_W'(best_idx_q);
				empty_res     <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/nam_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// nam_ctrl: sequencer of the nearest angle matcher
// Steps accept, wrap, execute, scan, drain and result; owns both channel handshakes.
// ----------------------------------------------------------------------------
module nam_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output nam_pkg::nam_cmd_t  cmd,
	input  nam_pkg::nam_stat_t stat
);
	import nam_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRAP,
		ST_EXEC,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} state_t;

	state_t             state_q;
	logic [WSTEP_W-1:0] step_q;
	logic               out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign out_free = !out_valid || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.load      = in_valid && in_ready;
		cmd.wrap_en   = (state_q == ST_WRAP);
		cmd.wrap_bit  = step_q;
		cmd.rd_en     = (state_q == ST_SCAN);
		cmd.out_load  = (state_q == ST_RESULT) && out_free;
		if (state_q == ST_EXEC) begin
			cmd.clear     = (stat.op == OP_CLEAR);
			cmd.append    = (stat.op == OP_APPEND);
			cmd.scan_init = (stat.op == OP_QUERY);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_WRAP;
						step_q  <= WSTEP_W'(WRAP_STEPS - 1);
					end
				end
				ST_WRAP: begin
					if (step_q == '0) begin
						state_q <= ST_EXEC;
					end else begin
						step_q <= step_q - WSTEP_W'(1);
					end
				end
				ST_EXEC: begin
					if (stat.op != OP_QUERY) begin
						state_q <= ST_IDLE;
					end else if (stat.count_zero) begin
						state_q <= ST_RESULT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (stat.rd_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== src/nearest_angle_matcher.sv =====
`default_nettype none
// Sequence: clear and append pass through the 6-step wrap reduction and the
//   execute step; a query on a filled store also scans it one entry per cycle,
//   drains the read register and loads the output register once it is free.
// Throughput: one item at a time; the next item is accepted only when idle.
// Reset: arst_n clears the fill count, sequencer and output valid; the store
//   itself is not cleared and entries above the fill count are never read.
// ----------------------------------------------------------------------------
// nearest_angle_matcher: nearest stored angle search
// Wraps every angle into [0, 2*pi) and answers queries with the closest
// stored candidate by plain absolute difference, earliest entry on ties.
// ----------------------------------------------------------------------------
module nearest_angle_matcher #(
	parameter int MAX_CANDIDATES = nam_pkg::MAX_CANDIDATES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	nam_req_if.sink   req,
	nam_rsp_if.source rsp
);
	import nam_pkg::*;

	nam_cmd_t  cmd;
	nam_stat_t stat;
	logic      in_ready;
	logic      out_valid;

	// Sequencer: walks each item through wrap, execute and (for a query) the
	// scan; the output register decouples the result from the next request.
	nam_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Datapath: reduction register, candidate store, running best and the
	// output item register.
	nam_datapath #(
		.MAX_CANDIDATES (MAX_CANDIDATES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.opcode        (req.opcode),
		.angle         (req.angle),
		.last_query    (req.last_query),
		.matched_angle (rsp.matched_angle),
		.matched_index (rsp.matched_index),
		.empty_res     (rsp.empty_res),
		.last          (rsp.last)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench of the nearest angle matcher
// A queue of clear/append/query items feeds a falling-edge driver; a rising-edge
// monitor predicts every match from its own copy of the candidate set and checks
// each returned item against the oldest pending prediction, in order.
// ----------------------------------------------------------------------------
module tb_top;
	import nam_pkg::*;

	// opcode 3 is not decoded by the block and must be ignored
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int NUM_ITEMS   = 1400;
	localparam int CYCLE_LIMIT = 500000;
	localparam int DRAIN_WAIT  = 40;     // longer than a query on a full store
	// both sides stop idling inside this window
	localparam int CALM_START  = 6000;
	localparam int CALM_END    = 12000;
	// receiver holds off once this many matches came back
	localparam int HOLD_AT     = 150;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic [OP_W-1:0]    op;
		logic [ANGLE_W-1:0] angle;
		logic               last_q;
		bit                 drain;   // sender waits for all matches before offering
	} req_item_t;

	typedef struct packed {
		logic [WANG_W-1:0]    matched_angle;
		logic [OUT_IDX_W-1:0] matched_index;
		logic                 empty_res;
		logic                 last;
	} match_t;

	logic clk = 1'b0;
	logic arst_n;

	nam_req_if req_ch ();
	nam_rsp_if rsp_ch ();

	nearest_angle_matcher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	req_item_t op_queue[$];          // items not yet offered
	match_t    pending_matches[$];   // predicted matches, oldest first

	// predictor copy of the candidate set
	logic [WANG_W-1:0] cand_q16[MAX_CANDIDATES_DEF];
	int                cand_cnt = 0;

	int  cycle_cnt    = 0;
	int  items_taken  = 0;
	int  results_seen = 0;
	int  err_cnt      = 0;
	int  total_items  = 0;
	bit  req_taken    = 1'b0;   // set at the accepting edge, consumed by the driver
	int  hold_left    = 0;
	bit  hold_done    = 1'b0;
	req_item_t next_item;

	// floored reduction into [0, 2*pi)
	function automatic int wrap_q16(logic [ANGLE_W-1:0] raw);
		int a;
		int r;
		a = int'($signed(raw));
		r = a % int'(TWO_PI_Q16);
		if (r < 0) begin
			r += int'(TWO_PI_Q16);
		end
		return r;
	endfunction

	// applies one item to the candidate set; returns 1 when it yields a match
	function automatic bit nearest_match(input req_item_t it, output match_t res);
		int w;
		int d;
		int best;
		int best_i;
		res    = '0;
		w      = wrap_q16(it.angle);
		best   = int'(START_BEST);
		best_i = 0;
		case (it.op)
			OP_CLEAR: begin
				cand_cnt = 0;
				return 1'b0;
			end
			OP_APPEND: begin
				// full store drops the append
				if (cand_cnt < MAX_CANDIDATES_DEF) begin
					cand_q16[cand_cnt] = WANG_W'(w);
					cand_cnt++;
				end
				return 1'b0;
			end
			OP_QUERY: begin
				res.last = it.last_q;
				if (cand_cnt == 0) begin
					res.empty_res = 1'b1;
					return 1'b1;
				end
				// plain |diff|, strict less keeps the earliest on ties
				for (int i = 0; i < cand_cnt; i++) begin
					d = w - int'(cand_q16[i]);
					if (d < 0) begin
						d = -d;
					end
					if (d < best) begin
						best   = d;
						best_i = i;
					end
				end
				res.matched_angle = cand_q16[best_i];
				res.matched_index = OUT_IDX_W'(best_i);
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	function automatic void add_item(logic [OP_W-1:0] op, int ang, logic lq, bit drain);
		req_item_t it;
		it.op     = op;
		it.angle  = ANGLE_W'(ang);
		it.last_q = lq;
		it.drain  = drain;
		op_queue.push_back(it);
	endfunction

	// random idle at about 12 in 100 calls, none inside the calm window
	function automatic bit idle_now();
		if (cycle_cnt >= CALM_START && cycle_cnt < CALM_END) begin
			return 1'b0;
		end
		return $urandom_range(99) < 12;
	endfunction

	// cycle counter and run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// request driver: changes only at the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_taken) begin
			req_taken = 1'b0;
			if (op_queue.size() != 0
					&& !(op_queue[0].drain && pending_matches.size() != 0)
					&& !idle_now()) begin
				next_item = op_queue.pop_front();
				req_ch.valid      <= 1'b1;
				req_ch.opcode     <= next_item.op;
				req_ch.angle      <= next_item.angle;
				req_ch.last_query <= next_item.last_q;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// response ready: one long hold-off, otherwise random stalls
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left    <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AT) begin
			hold_done    <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= !idle_now();
		end
	end

	// monitor: predict on accept, check on each returned match
	always @(posedge clk) begin
		req_item_t acc;
		match_t    want;
		match_t    got;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				acc.op     = req_ch.opcode;
				acc.angle  = req_ch.angle;
				acc.last_q = req_ch.last_query;
				acc.drain  = 1'b0;
				if (nearest_match(acc, want)) begin
					pending_matches.push_back(want);
				end
				req_taken = 1'b1;
				items_taken++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.matched_angle = rsp_ch.matched_angle;
				got.matched_index = rsp_ch.matched_index;
				got.empty_res     = rsp_ch.empty_res;
				got.last          = rsp_ch.last;
				results_seen++;
				if (pending_matches.size() == 0) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS) begin
						$display("unexpected match item: angle %0d index %0d empty %0b last %0b",
							got.matched_angle, got.matched_index, got.empty_res, got.last);
					end
				end else begin
					want = pending_matches.pop_front();
					if (got.matched_angle !== want.matched_angle
							|| got.matched_index !== want.matched_index
							|| got.empty_res !== want.empty_res
							|| got.last !== want.last) begin
						err_cnt++;
						if (err_cnt <= MAX_REPORTS) begin
							$display("match %0d: expected angle %0d index %0d empty %0b last %0b",
								results_seen, want.matched_angle, want.matched_index,
								want.empty_res, want.last);
							$display("match %0d:      got angle %0d index %0d empty %0b last %0b",
								results_seen, got.matched_angle, got.matched_index,
								got.empty_res, got.last);
						end
					end
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		int gen_raw[$];   // raw angles the set holds, as the generator sees it
		int a;
		int n;
		int m;
		int k;
		int j;
		int pick;
		int batch_no;
		logic [OP_W-1:0] op;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.opcode     = OP_CLEAR;
		req_ch.angle      = '0;
		req_ch.last_query = 1'b0;
		rsp_ch.ready      = 1'b0;
		batch_no          = 0;

		// directed: empty set with both last flags
		add_item(OP_QUERY, 0, 1'b1, 1'b0);
		add_item(OP_QUERY, -1, 1'b0, 1'b0);
		// angle extremes; 2*pi wraps to 0 and ties with the plain 0
		add_item(OP_APPEND, 8388607, 1'b0, 1'b0);
		add_item(OP_APPEND, -8388608, 1'b1, 1'b0);
		add_item(OP_APPEND, 0, 1'b0, 1'b0);
		add_item(OP_APPEND, int'(TWO_PI_Q16), 1'b0, 1'b0);
		add_item(OP_APPEND, -1, 1'b0, 1'b0);
		add_item(OP_QUERY, -8388608, 1'b0, 1'b0);
		add_item(OP_QUERY, 8388607, 1'b0, 1'b0);
		add_item(OP_QUERY, 0, 1'b1, 1'b0);
		// undecoded opcode, no effect
		add_item(OP_UNUSED, 24'h5a5a5a, 1'b1, 1'b0);
		// fill to sixteen, then one append that must be dropped
		for (int i = 0; i < 11; i++) begin
			add_item(OP_APPEND, 1000 + i * 37000, i[0], 1'b0);
		end
		add_item(OP_APPEND, 100000, 1'b0, 1'b0);
		add_item(OP_QUERY, 100000, 1'b1, 1'b0);
		add_item(OP_CLEAR, 0, 1'b0, 1'b0);
		add_item(OP_QUERY, int'(TWO_PI_Q16) - 1, 1'b1, 1'b0);

		// random: mostly clear / appends / query batches, some noise
		while (op_queue.size() < NUM_ITEMS + 26) begin
			if ($urandom_range(99) < 80) begin
				batch_no++;
				gen_raw.delete();
				add_item(OP_CLEAR, $urandom, 1'($urandom_range(1)), batch_no % 40 == 20);
				pick = $urandom_range(99);
				n = (pick < 70) ? $urandom_range(6, 1) :
					(pick < 90) ? $urandom_range(15, 7) : $urandom_range(19, 16);
				for (int i = 0; i < n; i++) begin
					pick = $urandom_range(99);
					if (pick < 45) begin
						a = $urandom;
					end else if (pick < 60) begin
						a = int'($urandom_range(40)) - 20;
					end else if (pick < 75) begin
						a = int'(TWO_PI_Q16) + int'($urandom_range(40)) - 20;
					end else if (pick < 85 && gen_raw.size() != 0) begin
						a = gen_raw[$urandom_range(gen_raw.size() - 1)];
					end else begin
						case ($urandom_range(3))
							0: a = -8388608;
							1: a = 8388607;
							2: a = 20 * int'(TWO_PI_Q16);
							default: a = -20 * int'(TWO_PI_Q16);
						endcase
					end
					add_item(OP_APPEND, a, 1'($urandom_range(1)), 1'b0);
					if (gen_raw.size() < MAX_CANDIDATES_DEF) begin
						gen_raw.push_back(int'($signed(ANGLE_W'(a))));
					end
				end
				m = $urandom_range(5, 1);
				for (int q = 0; q < m; q++) begin
					pick = $urandom_range(99);
					if (gen_raw.size() == 0 || pick >= 90) begin
						a = $urandom;
					end else begin
						k = $urandom_range(gen_raw.size() - 1);
						if (pick < 35) begin
							a = gen_raw[k] + int'($urandom_range(64)) - 32;
						end else if (pick < 50) begin
							a = gen_raw[k];
						end else if (pick < 65) begin
							// same wrapped angle, different turn
							a = gen_raw[k] + (int'($urandom_range(40)) - 20) * int'(TWO_PI_Q16);
						end else begin
							// midway between two entries: exact tie when the gap is even
							j = $urandom_range(gen_raw.size() - 1);
							a = (wrap_q16(ANGLE_W'(gen_raw[k])) + wrap_q16(ANGLE_W'(gen_raw[j]))) / 2;
						end
					end
					add_item(OP_QUERY, a, q == m - 1, 1'b0);
				end
			end else begin
				op = OP_W'($urandom_range(3));
				a  = $urandom;
				add_item(op, a, 1'($urandom_range(1)), 1'b0);
				if (op == OP_CLEAR) begin
					gen_raw.delete();
				end else if (op == OP_APPEND && gen_raw.size() < MAX_CANDIDATES_DEF) begin
					gen_raw.push_back(int'($signed(ANGLE_W'(a))));
				end
			end
		end
		total_items = op_queue.size();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (items_taken != total_items) begin
			@(negedge clk);
		end
		while (pending_matches.size() != 0) begin
			@(negedge clk);
		end
		// catch any stray item after the last expected one
		repeat (DRAIN_WAIT) @(negedge clk);

		if (err_cnt == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
